### hdl/khcf_pkg.sv
// ----------------------------------------------------------------------------
// khcf_pkg
// Shared types and constants of the height cell fusion block.
// ----------------------------------------------------------------------------
package khcf_pkg;

   // default number of grid cells
   localparam int CELL_COUNT_DEF = 4096;

   // field widths
   localparam int INDEX_W   = 12;
   localparam int HEIGHT_W  = 32;
   localparam int VAR_W     = 32;
   localparam int STAMP_W   = 32;
   localparam int SUPPORT_W = 16;
   localparam int OUTCOME_W = 2;
   localparam int GATE_W    = 16;

   // stream widths
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = OUTCOME_W;

   // register port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_VAR  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VAR      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE         = 8'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTLIER_VAR  = 8'd4;

   // register reset values
   localparam logic [31:0] MAX_AGE_RST     = 32'd2000;
   localparam logic [31:0] PROCESS_VAR_RST = 32'd17;
   localparam logic [31:0] MAX_VAR_RST     = 32'd16777216;
   localparam logic [15:0] GATE_RST        = 16'd768;
   localparam logic [31:0] OUTLIER_VAR_RST = 32'd167772;

   // posterior variance floor (1e-6 in Q8.24) and support ceiling
   localparam logic [VAR_W-1:0]     VAR_FLOOR   = 32'd17;
   localparam logic [SUPPORT_W-1:0] SUPPORT_MAX = 16'hFFFF;

   // result kinds
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_RESTART = 2'd0,
      OUT_FUSED   = 2'd1,
      OUT_OUTLIER = 2'd2
   } outcome_type;

   // one stored cell
   typedef struct packed {
      logic                 valid;
      logic [HEIGHT_W-1:0]  mean;
      logic [VAR_W-1:0]     variance;
      logic [STAMP_W-1:0]   stamp;
      logic [SUPPORT_W-1:0] count;
   } cell_entry_type;

   localparam int ENTRY_W = $bits(cell_entry_type);

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PRIOR,
      ST_SQUARE,
      ST_GATE,
      ST_DIV_MEAN,
      ST_WAIT_MEAN,
      ST_WAIT_VAR,
      ST_WRITE
   } state_type;

   // divider width
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 33;

endpackage

### hdl/khcf_ram.sv
// ----------------------------------------------------------------------------
// khcf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module khcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/khcf_div.sv
// ----------------------------------------------------------------------------
// khcf_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module khcf_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [khcf_pkg::DIV_NUM_W-1:0]     numer,
   input  logic [khcf_pkg::DIV_DEN_W-1:0]     denom,
   output logic                               done,
   output logic [khcf_pkg::DIV_NUM_W-1:0]     quot
);
   import khcf_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W:0]   trial;

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, quot_ff[DIV_NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         quot_in = numer;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DIV_DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DIV_DEN_W-1:0];
            quot_in = {quot_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### hdl/kalman_height_cell_fusion.sv
// ----------------------------------------------------------------------------
// kalman_height_cell_fusion
// Per-cell scalar Kalman fusion of height samples with innovation gating.
// Paths: restart ST_READ, ST_EVAL, ST_WRITE; outlier adds ST_PRIOR, ST_SQUARE
//   and ST_GATE; fused adds ST_DIV_MEAN and two 64-step divisions, which dominate.
// Flow: one beat at a time; the next request can be taken in the cycle after
//   the result enters the output register.
// Reset: synchronous; a clearing pass zeroes each of the CELL_COUNT cells of
//   the store, during which no request is accepted.
// ----------------------------------------------------------------------------
module kalman_height_cell_fusion #(
   parameter int CELL_COUNT = khcf_pkg::CELL_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: cell_index, measurement, meas_var, stamp_ms
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [khcf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response: fused_height, fused_variance, cell_support
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [khcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // response: outcome
   output logic [khcf_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [khcf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [khcf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import khcf_pkg::*;

   localparam int AW = $clog2(CELL_COUNT);
   localparam logic [31:0] CC = 32'(CELL_COUNT);

   // registers
   logic [31:0] max_age_ff, pvar_ff, max_var_ff, ov_ff;
   logic [15:0] gate_ff;
   logic [31:0] g2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MAX_AGE_RST;
         pvar_ff    <= PROCESS_VAR_RST;
         max_var_ff <= MAX_VAR_RST;
         gate_ff    <= GATE_RST;
         ov_ff      <= OUTLIER_VAR_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_AGE:     max_age_ff <= csr_data;
            CSR_PROCESS_VAR: pvar_ff    <= csr_data;
            CSR_MAX_VAR:     max_var_ff <= csr_data;
            CSR_GATE:        gate_ff    <= csr_data[15:0];
            CSR_OUTLIER_VAR: ov_ff      <= csr_data;
            default: ;
         endcase
      end
      g2_ff <= 32'(gate_ff) * 32'(gate_ff);
   end

   assign csr_ready = 1'b1;

   // request fields
   logic [INDEX_W-1:0]  req_index;
   logic [HEIGHT_W-1:0] req_meas;
   logic [VAR_W-1:0]    req_mvar;
   logic [STAMP_W-1:0]  req_stamp;
   assign req_index = req_tdata[11:0];
   assign req_meas  = req_tdata[43:12];
   assign req_mvar  = req_tdata[75:44];
   assign req_stamp = req_tdata[107:76];

   // cell index modulo CELL_COUNT (for CELL_COUNT of 16 or more), eight compare-subtract steps
   logic [31:0] mod_rem;
   always_comb begin
      mod_rem = 32'(req_index);
      for (int k = 7; k >= 0; k--) begin
         if (mod_rem >= (CC << k)) begin
            mod_rem = mod_rem - (CC << k);
         end
      end
   end

   // sequencer and datapath registers
   state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [AW-1:0]       cell_ff;
   logic [HEIGHT_W-1:0] meas_ff;
   logic [VAR_W-1:0]    mvar_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   cell_entry_type      old_ff, rd_entry;
   logic                neg_ff;
   logic [31:0]         mag_ff;
   logic [31:0]         prior_ff;
   logic [32:0]         s_ff;
   logic [63:0]         sq_ff;
   logic [65:0]         mul_ff;
   logic [32:0]         mul_a, mul_b;
   cell_entry_type      new_ff, new_in;
   outcome_type         outc_ff, outc_in;
   logic [ENTRY_W-1:0]  rd_data;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;

   logic                div_start, div_done;
   logic [63:0]         div_num, div_q;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                rsp_load;

   // combinational helpers
   logic [32:0] elapsed;
   logic [31:0] dt_c;
   logic        restart;
   logic [32:0] innov;
   logic [64:0] grown;
   logic [31:0] prior_c;
   logic [32:0] s_c;
   logic [71:0] gate_lhs;
   logic        outlier;
   logic [32:0] out_var;
   logic [63:0] var_q;

   assign rd_entry = cell_entry_type'(rd_data);
   assign elapsed  = {1'b0, stamp_ff} - {1'b0, rd_entry.stamp};
   // older stamps count as no elapsed time
   assign dt_c     = elapsed[32] ? 32'd0 : elapsed[31:0];
   assign restart  = !rd_entry.valid
                     || ($signed({elapsed[32], elapsed}) > $signed({2'b00, max_age_ff}));
   assign innov    = {meas_ff[31], meas_ff} - {rd_entry.mean[31], rd_entry.mean};
   assign grown    = 65'(old_ff.variance) + 65'(mul_ff[63:0]);
   assign prior_c  = (grown < 65'(max_var_ff)) ? grown[31:0] : max_var_ff;
   assign s_c      = 33'(prior_c) + 33'(mvar_ff);
   assign gate_lhs = {sq_ff, 8'h00};
   assign outlier  = (old_ff.count != '0) && (gate_lhs > 72'(mul_ff));
   assign out_var  = 33'(prior_ff) + 33'(ov_ff);
   assign var_q    = div_q;

   // shared multiplier operands by step
   always_comb begin
      case (state_ff)
         ST_EVAL:   begin mul_a = 33'(pvar_ff);  mul_b = 33'(dt_c);   end
         ST_PRIOR:  begin mul_a = 33'(mag_ff);   mul_b = 33'(mag_ff); end
         ST_SQUARE: begin mul_a = 33'(g2_ff);    mul_b = s_ff;        end
         ST_GATE:   begin mul_a = 33'(prior_ff); mul_b = 33'(mag_ff); end
         default:   begin mul_a = 33'(prior_ff); mul_b = 33'(mvar_ff);end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // next state and control
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      new_in    = new_ff;
      outc_in   = outc_ff;
      ram_we    = 1'b0;
      ram_waddr = cell_ff;
      ram_wdata = ENTRY_W'(new_ff);
      ram_re    = 1'b0;
      div_start = 1'b0;
      div_num   = 64'(mul_ff[63:0]) + 64'(s_ff[32:1]);
      rsp_load  = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (restart) begin
               new_in.valid    = 1'b1;
               new_in.mean     = meas_ff;
               new_in.variance = mvar_ff;
               new_in.stamp    = stamp_ff;
               new_in.count    = SUPPORT_W'(1);
               outc_in  = OUT_RESTART;
               state_in = ST_WRITE;
            end else begin
               new_in       = rd_entry;
               new_in.stamp = stamp_ff;
               state_in     = ST_PRIOR;
            end
         end
         ST_PRIOR: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            state_in = ST_GATE;
         end
         ST_GATE: begin
            if (outlier) begin
               new_in.variance = (out_var < 33'(max_var_ff)) ? out_var[31:0] : max_var_ff;
               outc_in  = OUT_OUTLIER;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            // mul_ff holds prior * |innovation|
            div_start = 1'b1;
            state_in  = ST_WAIT_MEAN;
         end
         ST_WAIT_MEAN: begin
            if (div_done) begin
               new_in.mean = neg_ff ? (old_ff.mean - div_q[31:0])
                                    : (old_ff.mean + div_q[31:0]);
               // mul_ff now holds prior * measurement variance
               div_start = 1'b1;
               state_in  = ST_WAIT_VAR;
            end
         end
         ST_WAIT_VAR: begin
            if (div_done) begin
               if (var_q < 64'(VAR_FLOOR)) begin
                  new_in.variance = VAR_FLOOR;
               end else begin
                  new_in.variance = var_q[31:0];
               end
               if ((var_q < 64'(VAR_FLOOR) ? 64'(VAR_FLOOR) : var_q) > 64'(max_var_ff)) begin
                  new_in.variance = max_var_ff;
               end
               if (old_ff.count != SUPPORT_MAX) begin
                  new_in.count = old_ff.count + 1'b1;
               end
               outc_in  = OUT_FUSED;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ram_we   = 1'b1;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      new_ff  <= new_in;
      outc_ff <= outc_in;
      // capture accepted beat
      if (req_tvalid && req_tready) begin
         cell_ff  <= mod_rem[AW-1:0];
         meas_ff  <= req_meas;
         mvar_ff  <= req_mvar;
         stamp_ff <= req_stamp;
      end
      // stored cell and first step values
      if (state_ff == ST_EVAL) begin
         old_ff <= rd_entry;
         neg_ff <= innov[32];
         mag_ff <= innov[32] ? 32'(-innov) : innov[31:0];
      end
      if (state_ff == ST_PRIOR) begin
         prior_ff <= prior_c;
         s_ff     <= (s_c == '0) ? 33'd1 : s_c;
      end
      if (state_ff == ST_SQUARE) begin
         sq_ff <= mul_ff[63:0];
      end
   end

   // output register
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= {new_ff.count, new_ff.variance, new_ff.mean};
         rsp_user_ff <= outc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // cell store
   khcf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (cell_ff),
      .rd_data (rd_data)
   );

   // shared divider
   khcf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (s_ff),
      .done  (div_done),
      .quot  (div_q)
   );

endmodule

### hdl/khcf_checker.sv
// ----------------------------------------------------------------------------
// khcf_checker
// Port-level checks of the height cell fusion block, bound to the top level.
// ----------------------------------------------------------------------------
module khcf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [khcf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [khcf_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import khcf_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a reset cycle is followed by request ready low, as the clearing pass starts
   a_clear: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready during clearing pass");

   // restart always reports support of one
   a_restart_support: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OUT_RESTART) |-> (rsp_tdata[79:64] == 16'd1))
      else $error("restart without unit support");

   // only one beat in flight: a new request is not taken in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule

bind kalman_height_cell_fusion khcf_checker u_khcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/sv/kalman_height_cell_fusion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_height_cell_fusion_test
// Self-checking bench for the height cell fusion block. Samples go in on the
// request stream in random bursts and are predicted by a per-cell Kalman
// model kept here. Each response beat is checked against the oldest
// prediction, field by field, while the response side stalls on its own
// pattern. Register settings are swept between phases, the extremes included.
// ----------------------------------------------------------------------------
module kalman_height_cell_fusion_test;
   import khcf_pkg::*;

   localparam int  CELLS      = CELL_COUNT_DEF;
   localparam int  SETTLE     = 40;
   localparam longint LIMIT   = 3_000_000;

   typedef struct {
      logic [HEIGHT_W-1:0]  height;
      logic [VAR_W-1:0]     variance;
      logic [SUPPORT_W-1:0] support;
      outcome_type          outcome;
   } fused_cell_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow cell store and registers
   bit                   cell_ok   [CELLS];
   logic [HEIGHT_W-1:0]  cell_mu   [CELLS];
   logic [VAR_W-1:0]     cell_var  [CELLS];
   logic [STAMP_W-1:0]   cell_stamp[CELLS];
   logic [SUPPORT_W-1:0] cell_sup  [CELLS];
   logic [31:0] age_max     = MAX_AGE_RST;
   logic [31:0] growth_rate = PROCESS_VAR_RST;
   logic [31:0] var_cap     = MAX_VAR_RST;
   logic [15:0] gate_sd     = GATE_RST;
   logic [31:0] reject_var  = OUTLIER_VAR_RST;

   fused_cell_type pending_cells[$];
   int          failures = 0;
   longint      cycles = 0;
   int          burst_left = 0;
   logic [31:0] now_ms = 32'd1000;

   always #2 clock = ~clock;

   kalman_height_cell_fusion dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      // cell_index, measurement, meas_var, stamp_ms, pad
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      // fused_height, fused_variance, cell_support
      .rsp_tdata(rsp_tdata),
      // outcome
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Kalman step on the shadow store; queues the expected response
   task automatic fuse_predict(input logic [11:0] idx, input logic [31:0] meas,
                               input logic [31:0] mvar, input logic [31:0] stamp);
      longint      elapsed, mean, innov;
      logic [63:0] dt, grown, prior, s, mag, quot, nm, v;
      logic [127:0] lhs, rhs;
      bit          reject;
      fused_cell_type r;
      elapsed = longint'({32'd0, stamp}) - longint'({32'd0, cell_stamp[idx]});
      if (!cell_ok[idx] || elapsed > longint'({32'd0, age_max})) begin
         cell_ok[idx]    = 1'b1;
         cell_mu[idx]    = meas;
         cell_var[idx]   = mvar;
         cell_stamp[idx] = stamp;
         cell_sup[idx]   = 16'd1;
         r.outcome = OUT_RESTART;
      end else begin
         dt    = elapsed > 0 ? 64'(elapsed) : 64'd0;
         grown = {32'd0, cell_var[idx]} + {32'd0, growth_rate} * dt;
         prior = grown < {32'd0, var_cap} ? grown : {32'd0, var_cap};
         s     = prior + {32'd0, mvar};
         if (s == 0) s = 1;
         mean  = longint'($signed(cell_mu[idx]));
         innov = longint'($signed(meas)) - mean;
         mag   = innov < 0 ? 64'(-innov) : 64'(innov);
         reject = 1'b0;
         // gate: innovation^2 in Q.40 against threshold^2 * S
         if (cell_sup[idx] != 0) begin
            lhs = {64'd0, mag * mag};
            lhs = lhs << 8;
            rhs = {112'd0, gate_sd} * {112'd0, gate_sd} * {64'd0, s};
            reject = lhs > rhs;
         end
         if (reject) begin
            v = prior + {32'd0, reject_var};
            cell_var[idx] = v < {32'd0, var_cap} ? v[31:0] : var_cap;
            r.outcome = OUT_OUTLIER;
         end else begin
            quot = (prior * mag + (s >> 1)) / s;
            nm   = innov < 0 ? 64'(mean) - quot : 64'(mean) + quot;
            v    = (prior * {32'd0, mvar} + (s >> 1)) / s;
            if (v < {32'd0, VAR_FLOOR}) v = {32'd0, VAR_FLOOR};
            if (v > {32'd0, var_cap}) v = {32'd0, var_cap};
            cell_mu[idx]  = nm[31:0];
            cell_var[idx] = v[31:0];
            if (cell_sup[idx] != SUPPORT_MAX) cell_sup[idx]++;
            r.outcome = OUT_FUSED;
         end
         cell_stamp[idx] = stamp;
      end
      r.height   = cell_mu[idx];
      r.variance = cell_var[idx];
      r.support  = cell_sup[idx];
      pending_cells.insert(pending_cells.size(), r);
   endtask

   // one request beat; valid stays up into the next beat unless a gap follows
   task automatic send_sample(input logic [11:0] idx, input logic [31:0] meas,
                              input logic [31:0] mvar, input logic [31:0] stamp);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, stamp, mvar, meas, idx};
      do @(posedge clock); while (!req_tready);
      fuse_predict(idx, meas, mvar, stamp);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write, only issued while the block is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAX_AGE:     age_max     = value;
         CSR_PROCESS_VAR: growth_rate = value;
         CSR_MAX_VAR:     var_cap     = value;
         CSR_GATE:        gate_sd     = value[15:0];
         CSR_OUTLIER_VAR: reject_var  = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] age, input logic [31:0] rate,
                                 input logic [31:0] cap, input logic [15:0] gate,
                                 input logic [31:0] rej);
      wait_drained();
      write_reg(CSR_MAX_AGE, age);
      write_reg(CSR_PROCESS_VAR, rate);
      write_reg(CSR_MAX_VAR, cap);
      write_reg(CSR_GATE, {16'd0, gate});
      write_reg(CSR_OUTLIER_VAR, rej);
   endtask

   // mostly well-formed tracks on a few cells, with outliers, stale stamps, age-outs and noise
   task automatic random_sample();
      logic [11:0] idx;
      logic [31:0] meas, mvar, stamp;
      int kind;
      kind = $urandom_range(0, 99);
      idx  = 12'($urandom_range(0, 15));
      if (kind < 12) begin
         fuse_noise: begin
            idx = 12'($urandom); meas = $urandom; mvar = $urandom; stamp = $urandom;
         end
      end else begin
         now_ms = now_ms + $urandom_range(0, 60);
         stamp  = now_ms;
         mvar   = $urandom_range(1, 32'h0200_0000);
         meas   = cell_mu[idx] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         if (kind < 25) meas = meas + ($urandom | 32'h0010_0000);
         else if (kind < 32) stamp = now_ms - $urandom_range(0, 3000);
         else if (kind < 36) stamp = now_ms + $urandom_range(2000, 100000);
         if (stamp > now_ms) now_ms = stamp;
      end
      send_sample(idx, meas, mvar, stamp);
   endtask

   task automatic test_directed();
      send_sample(12'd0, 32'h0001_0000, 32'h0100_0000, 32'd100);
      send_sample(12'd0, 32'h0001_8000, 32'h0080_0000, 32'd110);
      send_sample(12'd0, 32'h7FFF_FFFF, 32'h0000_0001, 32'd120);   // outlier
      send_sample(12'd0, 32'h0001_4000, 32'd0, 32'd90);            // stale stamp
      send_sample(12'd0, 32'h0001_4000, 32'hFFFF_FFFF, 32'd90);
      send_sample(12'd0, 32'h0002_0000, 32'h0100_0000, 32'd5000);  // aged out
      send_sample(12'd4095, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(12'd4095, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(12'd4095, 32'h8000_0000, 32'd0, 32'd0);
      send_sample(12'd1, 32'hFFFF_0000, 32'd0, 32'd0);
      send_sample(12'd1, 32'hFFFF_0000, 32'd0, 32'd0);              // zero S
      send_sample(12'd1, 32'hFFFE_8000, 32'd17, 32'd2000);          // age edge
      send_sample(12'd1, 32'hFFFE_8000, 32'd17, 32'd4001);
      send_sample(12'd2, 32'h0000_0000, 32'h0000_1000, 32'd7);
      send_sample(12'd2, 32'h0003_0000, 32'h0000_1000, 32'd7);
      send_sample(12'd2, 32'hFFFD_0000, 32'h0000_1000, 32'd8);
   endtask

   task automatic test_register_extremes();
      apply_settings(32'd0, 32'd0, 32'd17, 16'd0, 32'd0);
      repeat (30) random_sample();
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      repeat (40) random_sample();
      apply_settings(32'd50, 32'd1000, 32'h0400_0000, 16'd256, 32'h0010_0000);
      repeat (40) random_sample();
      apply_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
      repeat (30) random_sample();
      apply_settings(MAX_AGE_RST, PROCESS_VAR_RST, MAX_VAR_RST, GATE_RST, OUTLIER_VAR_RST);
   endtask

   task automatic test_random_tracks();
      repeat (300) random_sample();
      wait_drained();   // sender holds off until every response is back
      repeat (300) random_sample();
   endtask

   // response side: stall pattern that changes mode now and then
   int stall_mode = 0, mode_left = 0, phase = 0;
   always @(posedge clock) begin
      fused_cell_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            $error("response beat with no prediction pending");
            failures++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_tdata[31:0] !== want.height) begin
               $error("fused_height exp %h got %h", want.height, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[63:32] !== want.variance) begin
               $error("fused_variance exp %h got %h", want.variance, rsp_tdata[63:32]);
               failures++;
            end
            if (rsp_tdata[79:64] !== want.support) begin
               $error("cell_support exp %h got %h", want.support, rsp_tdata[79:64]);
               failures++;
            end
            if (rsp_tuser !== want.outcome) begin
               $error("outcome exp %0d got %0d", want.outcome, rsp_tuser);
               failures++;
            end
         end
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(100, 600);
      end
      mode_left--;
      phase++;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= (phase % 4) != 0;
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (phase % 32) < 4;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         cell_ok[i] = 1'b0; cell_mu[i] = '0; cell_var[i] = '0;
         cell_stamp[i] = '0; cell_sup[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_tracks();
      wait_drained();
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
hdl/khcf_pkg.sv
hdl/khcf_ram.sv
hdl/khcf_div.sv
hdl/kalman_height_cell_fusion.sv
hdl/khcf_checker.sv
tb/sv/kalman_height_cell_fusion_test.sv
